// File: hdl/rlse_pkg.sv
// ---------------------------------------------------------------------------
// rlse_pkg
// Types, constants and helpers shared by the RGB LED SPI bit encoder.
// ---------------------------------------------------------------------------
package rlse_pkg;

    localparam int          BITS_PER_PIXEL = 24;
    localparam int          BIT_CNT_W      = 5;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_PIXEL - 1);

    localparam logic [7:0]  SYM_ONE          = 8'hF8;
    localparam logic [7:0]  SYM_ZERO         = 8'hC0;
    localparam logic [7:0]  BRIGHTNESS_RESET = 8'hFF;

    localparam int          PADDR_W        = 3;
    localparam logic [0:0]  REG_BRIGHTNESS = 1'b0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last_of_pixel;
    } result_t;

    // scaled pixel, green first on the wire
    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } grb_t;

    // floor(p / 255), exact for p up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'd1 + 17'(p[15:8]);
        return s[15:8];
    endfunction

endpackage

// File: hdl/rlse_front.sv
// ---------------------------------------------------------------------------
// rlse_front
// Accepts pixels, scales each channel by brightness and packs them GRB.
// ---------------------------------------------------------------------------
module rlse_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  rlse_pkg::pixel_t pixel,
    input  logic [7:0]      brightness,
    output logic            q_push,
    input  logic            q_full,
    output rlse_pkg::grb_t  q_word
);
    import rlse_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [15:0] prod_r_reg;
    logic [15:0] prod_g_reg;
    logic [15:0] prod_b_reg;
    logic        advance;

    assign advance       = !s1_valid_reg || !q_full;
    assign full          = !advance;
    assign s1_valid_next = advance ? push : s1_valid_reg;
    assign q_push        = s1_valid_reg && !q_full;

    always_comb
    begin
        q_word.green = div255(prod_g_reg);
        q_word.red   = div255(prod_r_reg);
        q_word.blue  = div255(prod_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            prod_r_reg <= 16'(pixel.red)   * 16'(brightness);
            prod_g_reg <= 16'(pixel.green) * 16'(brightness);
            prod_b_reg <= 16'(pixel.blue)  * 16'(brightness);
        end
    end

endmodule

// File: hdl/rlse_fifo.sv
// ---------------------------------------------------------------------------
// rlse_fifo
// Short queue of scaled pixels between the front and the serializer.
// ---------------------------------------------------------------------------
module rlse_fifo #(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  rlse_pkg::grb_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output rlse_pkg::grb_t rd_data,
    output logic           q_empty
);
    import rlse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    grb_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/rlse_back.sv
// ---------------------------------------------------------------------------
// rlse_back
// Serializer: turns each queued GRB word into 24 SPI symbol bytes, MSB first.
// ---------------------------------------------------------------------------
module rlse_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  rlse_pkg::grb_t    q_word,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output rlse_pkg::result_t result
);
    import rlse_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [23:0]          shift_reg;
    logic [23:0]          shift_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic                 take;
    logic                 at_last;

    assign at_last = (cnt_reg == LAST_BIT);
    assign take    = busy_reg && pop;
    assign q_pop   = !q_empty && (!busy_reg || (take && at_last));
    assign empty   = !busy_reg;

    assign result.spi_byte      = shift_reg[23] ? SYM_ONE : SYM_ZERO;
    assign result.last_of_pixel = at_last;

    always_comb
    begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (q_pop)
        begin
            busy_next  = 1'b1;
            shift_next = q_word;
            cnt_next   = '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                shift_next = {shift_reg[22:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    a_mid_pixel_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !at_last) |=> !empty)
        else $error("serializer went idle inside a pixel");

    a_shift_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !at_last) |=> (shift_reg == {$past(shift_reg[22:0]), 1'b0}))
        else $error("symbol word did not advance by one bit");

    a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !q_empty) |=> (busy_reg && cnt_reg == '0))
        else $error("serializer idle while queue holds an item");

endmodule

// File: hdl/rgb_led_spi_bit_encoder_core.sv
// ---------------------------------------------------------------------------
// rgb_led_spi_bit_encoder_core
// Addressable RGB LED SPI encoder: brightness scaling and bit-to-byte coding.
// ---------------------------------------------------------------------------
// Each pushed pixel yields 24 result items, one SPI byte per LED data bit
// (0xF8 for one, 0xC0 for zero) in green, red, blue order, MSB first, with
// last_of_pixel set on the 24th. The serializer emits one byte per cycle while
// pop is held, and loads the next queued pixel as the last byte is taken. A
// pixel passes the front product register, the queue and the shift register.
// The front scales by brightness and holds up to QUEUE_DEPTH + 1 pixels ahead
// of the serializer, so input pushes continue while results are still
// draining. Brightness is at byte address 0 and resets to 255.
module rgb_led_spi_bit_encoder_core #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  rlse_pkg::pixel_t                pixel,
    output logic                            empty,
    input  logic                            pop,
    output rlse_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rlse_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rlse_pkg::*;

    logic [7:0] brightness_reg;
    logic       reg_hit;
    logic       cfg_wr;
    logic       f_push;
    logic       f_full;
    logic       f_empty;
    logic       f_pop;
    grb_t       f_wr_word;
    grb_t       f_rd_word;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_BRIGHTNESS);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {24'd0, brightness_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RESET;
        end
        else if (cfg_wr)
        begin
            brightness_reg <= pwdata[7:0];
        end
    end

    rlse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .brightness (brightness_reg),
        .q_push     (f_push),
        .q_full     (f_full),
        .q_word     (f_wr_word)
    );

    rlse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_wr_word),
        .q_full  (f_full),
        .rd_en   (f_pop),
        .rd_data (f_rd_word),
        .q_empty (f_empty)
    );

    rlse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (f_empty),
        .q_word  (f_rd_word),
        .q_pop   (f_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: verif/rlse_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlse_stream_checker
// Watches the pixel, result and register channels of the LED SPI encoder.
// ---------------------------------------------------------------------------
// Keeps its own brightness copy from observed register writes, turns every
// accepted pixel into the 24 expected SPI symbols and compares each popped
// result item with the oldest expected one. Reports the mismatch count and
// the number of symbols still outstanding.
module rlse_stream_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  rlse_pkg::pixel_t             pixel,
    input  logic                         empty,
    input  logic                         pop,
    input  rlse_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [rlse_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output int                           errors,
    output int                           pending
);
    import rlse_pkg::*;

    localparam logic [PADDR_W-1:0] BRIGHTNESS_ADDR = PADDR_W'(4 * REG_BRIGHTNESS);

    result_t    expected_symbols[$];
    logic [7:0] brightness = BRIGHTNESS_RESET;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        errors++;
    endtask

    // floor(c * b / 255)
    function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] b);
        int prod;
        prod = int'(c) * int'(b);
        return 8'(prod / 255);
    endfunction

    task automatic expect_pixel(input pixel_t px);
        logic [23:0] grb;
        result_t     sym;
        grb = {dim_channel(px.green, brightness), dim_channel(px.red, brightness),
               dim_channel(px.blue, brightness)};
        for (int k = 0; k < BITS_PER_PIXEL; k++)
        begin
            sym.spi_byte      = grb[BITS_PER_PIXEL-1-k] ? SYM_ONE : SYM_ZERO;
            sym.last_of_pixel = (k == BITS_PER_PIXEL - 1);
            expected_symbols.push_back(sym);
        end
    endtask

    task automatic check_symbol(input result_t got);
        result_t want;
        if (expected_symbols.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result item spi_byte=%h last=%b",
                                      got.spi_byte, got.last_of_pixel));
        end
        else
        begin
            want = expected_symbols.pop_front();
            if (got.spi_byte !== want.spi_byte)
                report_mismatch($sformatf("spi_byte: expected %h, got %h",
                                          want.spi_byte, got.spi_byte));
            if (got.last_of_pixel !== want.last_of_pixel)
                report_mismatch($sformatf("last_of_pixel: expected %b, got %b",
                                          want.last_of_pixel, got.last_of_pixel));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness = BRIGHTNESS_RESET;
            expected_symbols.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == BRIGHTNESS_ADDR)
                brightness = pwdata[7:0];
            if (push && !full)
                expect_pixel(pixel);
            if (pop && !empty)
                check_symbol(result);
            pending = expected_symbols.size();
        end
    end

endmodule

// File: verif/tb_rgb_led_spi_bit_encoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_led_spi_bit_encoder_core
// Stimulus and verdict for the RGB LED SPI bit encoder.
// ---------------------------------------------------------------------------
// Pushes a directed set of pixels (channel extremes, zero brightness, writes
// to an unmapped register, junk in the upper write data bits), then phases of
// random pixels under several brightness settings. Both sides stall at
// random, except during one calm phase. Checking is done by the stream
// checker instantiated beside the encoder.
module tb_rgb_led_spi_bit_encoder_core;
    import rlse_pkg::*;

    localparam int                 UNMAPPED_REG    = 1;
    localparam logic [PADDR_W-1:0] BRIGHTNESS_ADDR = PADDR_W'(4 * REG_BRIGHTNESS);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR   = PADDR_W'(4 * UNMAPPED_REG);
    localparam int                 CYCLE_LIMIT     = 300000;
    localparam int                 PHASE_PIXELS    = 25;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    pixel_t             pixel   = '0;
    logic               empty;
    logic               pop     = 1'b0;
    result_t            result;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int                 errors;
    int                 pending;
    int                 cycle_count = 0;
    logic               calm = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rgb_led_spi_bit_encoder_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rlse_stream_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= calm || ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pixel(input pixel_t px);
        if (!calm && $urandom_range(99) < 22)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
        push  <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    function automatic logic [7:0] random_channel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [31:0] phase_brightness[8];

        phase_brightness = '{32'h0000_00FF, 32'h0000_0000, 32'h0000_0001, 32'h0000_00FE,
                             32'h0000_0080, $urandom, $urandom, $urandom};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full brightness out of reset
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00));
        send_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
        send_pixel(make_pixel(8'h80, 8'h01, 8'hAA));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h0F));
        send_pixel(make_pixel(8'h7F, 8'hFE, 8'h01));
        drain();

        // unmapped register must not change brightness
        write_reg(UNMAPPED_ADDR, 32'h0000_0000);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        drain();

        // zero brightness, junk in upper data bits
        write_reg(BRIGHTNESS_ADDR, 32'hFFFF_FF00);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'h12, 8'h34, 8'h56));
        drain();

        write_reg(BRIGHTNESS_ADDR, 32'hA5A5_A501);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'hFE, 8'h80, 8'h7F));
        drain();

        write_reg(BRIGHTNESS_ADDR, 32'h0000_0080);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'h01, 8'h02, 8'h03));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(BRIGHTNESS_ADDR, phase_brightness[ph]);
            calm = (ph == 3);
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
            drain();
        end
        calm = 1'b0;

        repeat (40) @(negedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/rlse_pkg.sv
hdl/rlse_front.sv
hdl/rlse_fifo.sv
hdl/rlse_back.sv
hdl/rgb_led_spi_bit_encoder_core.sv
verif/rlse_stream_checker.sv
verif/tb_rgb_led_spi_bit_encoder_core.sv
